/* sv/sha1_pkg.sv */
package sha1_pkg;

  // input item and result item
  typedef struct packed {
    logic [31:0] data_word;
    logic [2:0]  valid_bytes;
    logic        last_word;
  } sha1_in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        digest_end;
  } sha1_out_t;

  // source of the byte appended to the block
  typedef enum logic [1:0] {
    SRC_DATA,
    SRC_PAD,
    SRC_ZERO,
    SRC_LEN
  } sha1_src_e;

  // round function groups, twenty rounds each
  localparam logic [1:0] STG_CH   = 2'd0;
  localparam logic [1:0] STG_PAR1 = 2'd1;
  localparam logic [1:0] STG_MAJ  = 2'd2;
  localparam logic [1:0] STG_PAR2 = 2'd3;

  localparam logic [31:0] SHA1_K0 = 32'h5A827999;
  localparam logic [31:0] SHA1_K1 = 32'h6ED9EBA1;
  localparam logic [31:0] SHA1_K2 = 32'h8F1BBCDC;
  localparam logic [31:0] SHA1_K3 = 32'hCA62C1D6;

  localparam int unsigned SHA1_NUM_HASH = 5;
  localparam logic [31:0] SHA1_H_INIT [SHA1_NUM_HASH] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  // byte positions within a 64-byte block
  localparam logic [5:0] SHA1_POS_LAST = 6'd63;
  localparam logic [5:0] SHA1_POS_LEN  = 6'd56;

  localparam logic [2:0] SHA1_MAX_BYTES   = 3'd4;
  localparam logic [2:0] SHA1_DIGEST_LAST = 3'd4;
  localparam logic [4:0] SHA1_RND_LAST    = 5'd19;

  // controller to datapath commands
  typedef struct packed {
    logic      take;
    logic      put;
    sha1_src_e src;
    logic [2:0] byte_idx;
    logic      len_latch;
    logic      init_work;
    logic      round;
    logic [1:0] stage;
    logic      add_hash;
    logic      reset_hash;
  } sha1_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic [5:0] pos;
    logic [2:0] nbytes;
    logic       last;
  } sha1_stat_t;

endpackage

/* sv/sha1_ctrl.sv */
module sha1_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [2:0]          out_index_o,
  input  sha1_pkg::sha1_stat_t stat_i,
  output sha1_pkg::sha1_cmd_t  cmd_o
);
  import sha1_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DATA = 3'd1;
  localparam logic [2:0] ST_PAD  = 3'd2;
  localparam logic [2:0] ST_ZERO = 3'd3;
  localparam logic [2:0] ST_LEN  = 3'd4;
  localparam logic [2:0] ST_COMP = 3'd5;
  localparam logic [2:0] ST_ADD  = 3'd6;
  localparam logic [2:0] ST_OUT  = 3'd7;

  logic [2:0] state_q, state_d;
  logic [2:0] ret_q, ret_d;
  logic [2:0] bidx_q, bidx_d;
  logic [4:0] rnd_q, rnd_d;
  logic [1:0] stg_q, stg_d;
  logic [2:0] oidx_q, oidx_d;
  logic       blk_full;

  // this put completes the block
  assign blk_full = (stat_i.pos == SHA1_POS_LAST);

  // next state and commands
  always_comb begin
    state_d = state_q;
    ret_d   = ret_q;
    bidx_d  = bidx_q;
    rnd_d   = rnd_q;
    stg_d   = stg_q;
    oidx_d  = oidx_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          bidx_d     = 3'd0;
          state_d    = ST_DATA;
        end
      end
      ST_DATA: begin
        if (bidx_q < stat_i.nbytes) begin
          cmd_o.put      = 1'b1;
          cmd_o.src      = SRC_DATA;
          cmd_o.byte_idx = bidx_q;
          bidx_d         = bidx_q + 3'd1;
          if (blk_full) begin
            cmd_o.init_work = 1'b1;
            ret_d   = ST_DATA;
            state_d = ST_COMP;
          end
        end else if (stat_i.last) begin
          state_d = ST_PAD;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_PAD: begin
        cmd_o.put       = 1'b1;
        cmd_o.src       = SRC_PAD;
        cmd_o.len_latch = 1'b1;
        state_d         = ST_ZERO;
        if (blk_full) begin
          cmd_o.init_work = 1'b1;
          ret_d   = ST_ZERO;
          state_d = ST_COMP;
        end
      end
      ST_ZERO: begin
        if (stat_i.pos == SHA1_POS_LEN) begin
          bidx_d  = 3'd0;
          state_d = ST_LEN;
        end else begin
          cmd_o.put = 1'b1;
          cmd_o.src = SRC_ZERO;
          if (blk_full) begin
            cmd_o.init_work = 1'b1;
            ret_d   = ST_ZERO;
            state_d = ST_COMP;
          end
        end
      end
      ST_LEN: begin
        cmd_o.put      = 1'b1;
        cmd_o.src      = SRC_LEN;
        cmd_o.byte_idx = bidx_q;
        bidx_d         = bidx_q + 3'd1;
        // the last length byte always closes the block
        if (blk_full) begin
          cmd_o.init_work = 1'b1;
          ret_d   = ST_OUT;
          state_d = ST_COMP;
        end
      end
      ST_COMP: begin
        cmd_o.round = 1'b1;
        cmd_o.stage = stg_q;
        if (rnd_q == SHA1_RND_LAST) begin
          rnd_d = 5'd0;
          if (stg_q == STG_PAR2) begin
            stg_d   = STG_CH;
            state_d = ST_ADD;
          end else begin
            stg_d = stg_q + 2'd1;
          end
        end else begin
          rnd_d = rnd_q + 5'd1;
        end
      end
      ST_ADD: begin
        cmd_o.add_hash = 1'b1;
        state_d        = ret_q;
      end
      ST_OUT: begin
        if (!out_stall_i) begin
          if (oidx_q == SHA1_DIGEST_LAST) begin
            cmd_o.reset_hash = 1'b1;
            oidx_d  = 3'd0;
            state_d = ST_IDLE;
          end else begin
            oidx_d = oidx_q + 3'd1;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ret_q   <= ST_IDLE;
      bidx_q  <= 3'd0;
      rnd_q   <= 5'd0;
      stg_q   <= STG_CH;
      oidx_q  <= 3'd0;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      bidx_q  <= bidx_d;
      rnd_q   <= rnd_d;
      stg_q   <= stg_d;
      oidx_q  <= oidx_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = (state_q == ST_OUT);
  assign out_index_o = oidx_q;

endmodule

/* sv/sha1_dp.sv */
module sha1_dp (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  sha1_pkg::sha1_in_t   in_data_i,
  input  sha1_pkg::sha1_cmd_t  cmd_i,
  input  logic [2:0]           out_index_i,
  output sha1_pkg::sha1_stat_t stat_o,
  output logic [31:0]          digest_o
);
  import sha1_pkg::*;

  logic [31:0] data_q;
  logic [2:0]  nbytes_q;
  logic        last_q;
  logic [63:0] cnt_q;
  logic [63:0] len_q;
  logic [31:0] acc_q;
  logic [31:0] w_q [16];
  logic [31:0] a_q, b_q, c_q, d_q, e_q;
  logic [31:0] h_q [SHA1_NUM_HASH];

  logic [1:0]  lane;
  logic [31:0] data_sh;
  logic [63:0] len_sh;
  logic [7:0]  put_byte;
  logic [31:0] acc_new;
  logic [31:0] sched_x;
  logic [31:0] sched_new;
  logic [31:0] f_val;
  logic [31:0] k_val;
  logic [31:0] tmp;

  assign lane = cnt_q[4:3];

  // byte to append
  assign data_sh = data_q << {cmd_i.byte_idx[1:0], 3'b000};
  assign len_sh  = len_q << {cmd_i.byte_idx, 3'b000};

  always_comb begin
    case (cmd_i.src)
      SRC_DATA: put_byte = data_sh[31:24];
      SRC_PAD:  put_byte = 8'h80;
      SRC_ZERO: put_byte = 8'h00;
      SRC_LEN:  put_byte = len_sh[63:56];
      default:  put_byte = 8'h00;
    endcase
  end

  // word assembly, first byte in the top lane
  always_comb begin
    if (lane == 2'd0) begin
      acc_new = {put_byte, 24'h000000};
    end else begin
      acc_new = acc_q | ({24'h000000, put_byte} << {~lane, 3'b000});
    end
  end

  // message schedule and round function
  assign sched_x   = w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0];
  assign sched_new = {sched_x[30:0], sched_x[31]};

  always_comb begin
    case (cmd_i.stage)
      STG_CH: begin
        f_val = (b_q & c_q) | (~b_q & d_q);
        k_val = SHA1_K0;
      end
      STG_PAR1: begin
        f_val = b_q ^ c_q ^ d_q;
        k_val = SHA1_K1;
      end
      STG_MAJ: begin
        f_val = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
        k_val = SHA1_K2;
      end
      STG_PAR2: begin
        f_val = b_q ^ c_q ^ d_q;
        k_val = SHA1_K3;
      end
      default: begin
        f_val = b_q ^ c_q ^ d_q;
        k_val = SHA1_K3;
      end
    endcase
  end

  assign tmp = {a_q[26:0], a_q[31:27]} + f_val + e_q + k_val + w_q[0];

  // captured item, message length, word assembly, block window and working variables
  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      data_q   <= in_data_i.data_word;
      nbytes_q <= (in_data_i.valid_bytes > SHA1_MAX_BYTES) ? SHA1_MAX_BYTES
                                                          : in_data_i.valid_bytes;
      last_q   <= in_data_i.last_word;
    end
    if (cmd_i.len_latch) begin
      len_q <= cnt_q;
    end
    if (cmd_i.put) begin
      acc_q <= acc_new;
      if (lane == 2'd3) begin
        for (int i = 0; i < 15; i++) begin
          w_q[i] <= w_q[i+1];
        end
        w_q[15] <= acc_new;
      end
    end
    if (cmd_i.round) begin
      for (int i = 0; i < 15; i++) begin
        w_q[i] <= w_q[i+1];
      end
      w_q[15] <= sched_new;
      a_q <= tmp;
      b_q <= a_q;
      c_q <= {b_q[1:0], b_q[31:2]};
      d_q <= c_q;
      e_q <= d_q;
    end
    if (cmd_i.init_work) begin
      a_q <= h_q[0];
      b_q <= h_q[1];
      c_q <= h_q[2];
      d_q <= h_q[3];
      e_q <= h_q[4];
    end
  end

  // hash words and bit count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 64'd0;
      for (int i = 0; i < SHA1_NUM_HASH; i++) begin
        h_q[i] <= SHA1_H_INIT[i];
      end
    end else if (cmd_i.reset_hash) begin
      cnt_q <= 64'd0;
      for (int i = 0; i < SHA1_NUM_HASH; i++) begin
        h_q[i] <= SHA1_H_INIT[i];
      end
    end else begin
      if (cmd_i.put) begin
        cnt_q <= cnt_q + 64'd8;
      end
      if (cmd_i.add_hash) begin
        h_q[0] <= h_q[0] + a_q;
        h_q[1] <= h_q[1] + b_q;
        h_q[2] <= h_q[2] + c_q;
        h_q[3] <= h_q[3] + d_q;
        h_q[4] <= h_q[4] + e_q;
      end
    end
  end

  assign stat_o.pos    = cnt_q[8:3];
  assign stat_o.nbytes = nbytes_q;
  assign stat_o.last   = last_q;
  assign digest_o      = h_q[out_index_i];

endmodule

/* sv/sha1_hash_engine.sv */
// The engine handles one item at a time: it takes the item, then appends its bytes one by one,
// and for each block it completes runs 80 rounds and the hash update before going on.
// The byte loop and the single round unit set its speed.
// A last item adds padding bytes, one or two more blocks, and five output transfers.
// Reset: hash words load the initial values, the bit count clears, the engine goes idle.
module sha1_hash_engine (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  sha1_pkg::sha1_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output sha1_pkg::sha1_out_t out_data_o
);
  import sha1_pkg::*;

  sha1_cmd_t  cmd;
  sha1_stat_t stat;
  logic [2:0]  out_index;
  logic [31:0] digest;

  // controller
  sha1_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_index_o (out_index),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // datapath
  sha1_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .out_index_i (out_index),
    .stat_o      (stat),
    .digest_o    (digest)
  );

  // result payload
  assign out_data_o.digest_word = digest;
  assign out_data_o.word_index  = out_index;
  assign out_data_o.digest_end  = (out_index == SHA1_DIGEST_LAST);

  // no input is taken while a digest is being delivered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input open during digest output");

  // an accepted item keeps the engine busy in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (in_stall_o && !out_valid_o))
    else $error("engine not busy after input transfer");

  // output ends after the final digest word transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && out_data_o.digest_end) |=> !out_valid_o)
    else $error("output continues after final digest word");

endmodule

/* sim/sha1_hash_engine_tb.sv */
module sha1_hash_engine_tb;
  import sha1_pkg::*;

  localparam int WORD_TARGET  = 380;
  localparam int IDLE_LIMIT   = 4000;
  localparam int DRAIN_CYCLES = 400;

  typedef enum int {
    RX_FREE,
    RX_RANDOM,
    RX_PATTERN,
    RX_HEAVY
  } rx_mode_e;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_stall_o;
  sha1_in_t  in_data_i   = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  sha1_out_t out_data_o;

  sha1_hash_engine dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always #5 clk_i = ~clk_i;

  // message words waiting to be sent, digest words waiting to come back
  sha1_in_t  word_q[$];
  sha1_out_t digest_q[$];

  int   word_total  = 0;
  int   words_taken = 0;
  int   err_cnt     = 0;
  int   idle_cnt    = 0;
  logic in_fired    = 1'b0;

  // running hash state of the expected engine
  logic [31:0] hash_h [SHA1_NUM_HASH];
  logic [31:0] blk_w  [16];
  logic [63:0] bit_len;

  function automatic logic [31:0] rotl(input logic [31:0] v, input int unsigned s);
    return (v << s) | (v >> (32 - s));
  endfunction

  task automatic hash_reset();
    for (int i = 0; i < SHA1_NUM_HASH; i++) hash_h[i] = SHA1_H_INIT[i];
    bit_len = '0;
  endtask

  // 80 rounds over the block buffer, folded into the hash words
  task automatic compress_block();
    logic [31:0] w [16];
    logic [31:0] a, b, c, d, e, f, k, wt, sum;
    logic [1:0]  stg;
    w = blk_w;
    a = hash_h[0];
    b = hash_h[1];
    c = hash_h[2];
    d = hash_h[3];
    e = hash_h[4];
    for (int t = 0; t < 80; t++) begin
      if (t < 16) begin
        wt = w[t];
      end else begin
        wt = rotl(w[(t + 13) % 16] ^ w[(t + 8) % 16] ^ w[(t + 2) % 16] ^ w[t % 16], 1);
        w[t % 16] = wt;
      end
      stg = 2'(t / 20);
      case (stg)
        STG_CH: begin
          f = (b & c) | (~b & d);
          k = SHA1_K0;
        end
        STG_PAR1: begin
          f = b ^ c ^ d;
          k = SHA1_K1;
        end
        STG_MAJ: begin
          f = (b & c) | (b & d) | (c & d);
          k = SHA1_K2;
        end
        default: begin
          f = b ^ c ^ d;
          k = SHA1_K3;
        end
      endcase
      sum = rotl(a, 5) + f + e + k + wt;
      e = d;
      d = c;
      c = rotl(b, 30);
      b = a;
      a = sum;
    end
    hash_h[0] += a;
    hash_h[1] += b;
    hash_h[2] += c;
    hash_h[3] += d;
    hash_h[4] += e;
  endtask

  // place one byte in the block buffer, compress when the block is full
  task automatic absorb_byte(input logic [7:0] bt);
    logic [5:0] pos;
    int         lane;
    pos  = bit_len[8:3];
    lane = pos[1:0];
    if (lane == 0) blk_w[pos[5:2]] = '0;
    blk_w[pos[5:2]] |= {24'd0, bt} << (8 * (3 - lane));
    bit_len += 64'd8;
    if (pos == SHA1_POS_LAST) compress_block();
  endtask

  // one accepted word; the final word pads, finishes and queues the digest
  task automatic absorb_word(input sha1_in_t it);
    int unsigned nb;
    logic [63:0] msg_bits;
    sha1_out_t   r;
    nb = (it.valid_bytes > SHA1_MAX_BYTES) ? SHA1_MAX_BYTES : it.valid_bytes;
    for (int i = 0; i < nb; i++) absorb_byte(it.data_word[31 - 8 * i -: 8]);
    if (it.last_word) begin
      msg_bits = bit_len;
      absorb_byte(8'h80);
      while (bit_len[8:3] != SHA1_POS_LEN) absorb_byte(8'h00);
      for (int i = 0; i < 8; i++) absorb_byte(msg_bits[63 - 8 * i -: 8]);
      for (int i = 0; i < SHA1_NUM_HASH; i++) begin
        r.digest_word = hash_h[i];
        r.word_index  = 3'(i);
        r.digest_end  = (3'(i) == SHA1_DIGEST_LAST);
        digest_q.push_back(r);
      end
      hash_reset();
    end
  endtask

  task automatic report(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    err_cnt++;
  endtask

  // stimulus helpers
  task automatic add_word(input logic [31:0] data, input logic [2:0] nb, input logic last);
    sha1_in_t it;
    it.data_word   = data;
    it.valid_bytes = nb;
    it.last_word   = last;
    word_q.push_back(it);
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 15))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // mostly full words, now and then a short, empty or oversized count
  task automatic add_message(input int body_words);
    logic [2:0] nb;
    for (int i = 0; i < body_words; i++) begin
      nb = ($urandom_range(0, 11) == 0) ? 3'($urandom_range(0, 7)) : SHA1_MAX_BYTES;
      add_word(rand_word(), nb, 1'b0);
    end
    add_word(rand_word(), 3'($urandom_range(0, 7)), 1'b1);
  endtask

  // sender: bursts of transfers separated by random gaps
  int burst_left = 1;
  int gap_left   = 0;

  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_fired)) begin
      if (gap_left > 0 || word_q.size() == 0) begin
        in_valid_i <= 1'b0;
        if (gap_left > 0) gap_left--;
      end else begin
        in_valid_i <= 1'b1;
        in_data_i  <= word_q.pop_front();
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 40);
          case ($urandom_range(0, 5))
            0, 1:    gap_left = 0;
            5:       gap_left = $urandom_range(20, 60);
            default: gap_left = $urandom_range(1, 6);
          endcase
        end
      end
    end
  end

  // receiver: stall behavior switches between free, random, pattern and heavy
  rx_mode_e    rx_mode  = RX_FREE;
  int          rx_span  = 0;
  logic [15:0] rx_pat   = '0;

  always @(negedge clk_i) begin
    if (rx_span == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 3));
      rx_span = $urandom_range(8, 120);
      rx_pat  = 16'($urandom);
    end else begin
      rx_span--;
    end
    case (rx_mode)
      RX_FREE:   out_stall_i <= 1'b0;
      RX_RANDOM: out_stall_i <= ($urandom_range(0, 2) == 0);
      RX_PATTERN: begin
        out_stall_i <= rx_pat[15];
        rx_pat = {rx_pat[14:0], rx_pat[15]};
      end
      default:   out_stall_i <= ($urandom_range(0, 5) != 0);
    endcase
  end

  // monitor: predict on input transfers, check output transfers, watchdog
  sha1_out_t exp_d;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      in_fired <= in_valid_i && !in_stall_o;
      if (in_valid_i && !in_stall_o) begin
        absorb_word(in_data_i);
        words_taken++;
      end
      if (out_valid_o && !out_stall_i) begin
        if (digest_q.size() == 0) begin
          report($sformatf("unexpected digest word %08h index %0d",
                           out_data_o.digest_word, out_data_o.word_index));
        end else begin
          exp_d = digest_q.pop_front();
          if (out_data_o.digest_word !== exp_d.digest_word)
            report($sformatf("digest_word %08h, expected %08h",
                             out_data_o.digest_word, exp_d.digest_word));
          if (out_data_o.word_index !== exp_d.word_index)
            report($sformatf("word_index %0d, expected %0d",
                             out_data_o.word_index, exp_d.word_index));
          if (out_data_o.digest_end !== exp_d.digest_end)
            report($sformatf("digest_end %0b, expected %0b",
                             out_data_o.digest_end, exp_d.digest_end));
        end
      end
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cnt = 0;
      end else begin
        idle_cnt++;
        if (idle_cnt >= IDLE_LIMIT) begin
          $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
          $display("CHECKS FAILED");
          $finish;
        end
      end
    end
  end

  // stimulus, reset and end of run
  int pick;

  initial begin
    hash_reset();

    // empty message, short message, oversized count on a last word, full word then empty last word
    add_word(32'h0000_0000, 3'd0, 1'b1);
    add_word(32'h6162_6300, 3'd3, 1'b1);
    add_word(32'hFFFF_FFFF, 3'd7, 1'b1);
    add_word(32'h0000_0000, 3'd4, 1'b0);
    add_word(32'h0000_0000, 3'd0, 1'b1);
    // partial, empty and oversized words ahead of the last one, then one oversized last word
    add_word(32'hA5FF_FFFF, 3'd1, 1'b0);
    add_word(32'hDEAD_BEEF, 3'd0, 1'b0);
    add_word(32'h1234_5678, 3'd2, 1'b0);
    add_word(32'hFFFF_FFFF, 3'd5, 1'b0);
    add_word(32'h0000_0000, 3'd6, 1'b0);
    add_word(32'hCAFE_F00D, 3'd4, 1'b1);
    add_word(32'h8000_0001, 3'd5, 1'b1);

    // random messages, weighted toward the one-or-two-block padding boundary
    while (word_q.size() < WORD_TARGET) begin
      pick = $urandom_range(0, 9);
      case (pick)
        0, 1, 2, 3: add_message($urandom_range(0, 4));
        4, 5, 6:    add_message($urandom_range(12, 17));
        7, 8:       add_message($urandom_range(5, 11));
        default:    add_message($urandom_range(27, 34));
      endcase
    end
    word_total = word_q.size();

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    wait (words_taken == word_total);
    wait (digest_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
sv/sha1_pkg.sv
sv/sha1_ctrl.sv
sv/sha1_dp.sv
sv/sha1_hash_engine.sv
sim/sha1_hash_engine_tb.sv
